/* rtl/cts_pkg.sv */
// Shared types, codes and constants of the cascaded tick scheduler.
`default_nettype none
package cts_pkg;

	// Field and register widths
	localparam int TICK_W          = 16;
	localparam int DIV_W           = 10;
	localparam int CFG_IDX_W       = 2;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int LEVELS          = 4;

	// Command codes
	localparam logic CMD_RUN  = 1'b0;
	localparam logic CMD_INIT = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DIV_MS_PER_10MS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIV_10MS_PER_100MS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIV_100MS_PER_SEC  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIV_SEC_PER_MIN    = 2'd3;

	// Configuration reset values
	localparam logic [DIV_W-1:0] DIV_MS_PER_10MS_RST    = 10'd10;
	localparam logic [DIV_W-1:0] DIV_10MS_PER_100MS_RST = 10'd10;
	localparam logic [DIV_W-1:0] DIV_100MS_PER_SEC_RST  = 10'd10;
	localparam logic [DIV_W-1:0] DIV_SEC_PER_MIN_RST    = 10'd60;

	// Cascade levels, each named after the level that fires
	localparam logic [1:0] LVL_10MS  = 2'd0;
	localparam logic [1:0] LVL_100MS = 2'd1;
	localparam logic [1:0] LVL_1S    = 2'd2;
	localparam logic [1:0] LVL_1MIN  = 2'd3;

	typedef struct packed {
		logic              command;
		logic [TICK_W-1:0] now_tick;
	} cts_in_t;

	typedef struct packed {
		logic [TICK_W-1:0] elapsed_ticks;
		logic              fire_10ms;
		logic [TICK_W-1:0] ticks_10ms;
		logic              fire_100ms;
		logic              fire_1s;
		logic              fire_1min;
		logic [TICK_W-1:0] minutes_total;
	} cts_out_t;

endpackage
`default_nettype wire

/* rtl/cts_div.sv */
// Restoring divider, one quotient bit per cycle, shared by all cascade levels.
`default_nettype none
module cts_div #(
	parameter int DW = cts_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [DW-1:0]            dividend,
	input  wire logic [cts_pkg::DIV_W-1:0] divisor,
	output logic                          done,
	output logic [DW-1:0]                 quotient,
	output logic [cts_pkg::DIV_W-1:0]     remainder
);

	localparam int VW = cts_pkg::DIV_W;
	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] num_q;
	logic [VW-1:0] rem_q;
	logic [VW:0]   trial_w;
	logic          ge_w;
	logic [VW:0]   diff_w;

	// Shift in the next dividend bit and try the subtraction
	assign trial_w = {rem_q, num_q[DW-1]};
	assign ge_w    = trial_w >= {1'b0, divisor};
	assign diff_w  = trial_w - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
				num_q  <= dividend;
				rem_q  <= '0;
			end else if (busy_q) begin
				// Keep the partial remainder, shift the quotient bit in
				rem_q <= ge_w ? diff_w[VW-1:0] : trial_w[VW-1:0];
				num_q <= {num_q[DW-2:0], ge_w};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = num_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

/* rtl/cascaded_tick_scheduler.sv */
// Top level of the cascaded tick scheduler: sequencer, counters and config registers.
//
// The block takes one item at a time. An init item, or a run item with no
// elapsed ticks, is absorbed in its accept cycle and the block is ready again
// in the next cycle. A run item that fires levels keeps the block busy while
// each fired level is divided in turn, because every level division goes
// through one shared restoring divider that produces one quotient bit per
// clock. The result sits in an output register, so the block accepts the next
// item while it waits; only a second result finding that register still full
// holds the sequencer.
// Configuration writes are always taken (cfg_ready is high).
`default_nettype none
module cascaded_tick_scheduler #(
	parameter int COUNT_WIDTH = cts_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire cts_pkg::cts_in_t             in_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output cts_pkg::cts_out_t                 out_data,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [cts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cts_pkg::DIV_W-1:0]    cfg_data
);

	localparam int TW    = cts_pkg::TICK_W;
	localparam int VW    = cts_pkg::DIV_W;
	localparam int CMP_W = (COUNT_WIDTH > VW) ? COUNT_WIDTH : VW;
	localparam int EXT_W = (COUNT_WIDTH > TW) ? COUNT_WIDTH : TW;

	typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_DIV, ST_DONE} state_t;

	state_t                        state_q;
	logic [1:0]                    level_q;
	logic [cts_pkg::LEVELS-1:0]    fire_q;
	logic [TW-1:0]                 last_tick_q;
	logic [TW-1:0]                 elapsed_q;
	logic [COUNT_WIDTH-1:0]        ticks_q;
	logic [COUNT_WIDTH-1:0]        ms_q;
	logic [COUNT_WIDTH-1:0]        tens_q;
	logic [COUNT_WIDTH-1:0]        hund_q;
	logic [COUNT_WIDTH-1:0]        sec_q;
	logic [COUNT_WIDTH-1:0]        min_q;
	logic [VW-1:0]                 div_q [cts_pkg::LEVELS];
	logic                          out_valid_q;
	cts_pkg::cts_out_t             out_data_q;

	logic                          in_acc_w;
	logic                          out_free_w;
	logic [TW-1:0]                 elapsed_w;
	logic [EXT_W-1:0]              ms_sum_w;
	logic [COUNT_WIDTH-1:0]        operand_w;
	logic [VW-1:0]                 div_raw_w;
	logic [VW-1:0]                 divisor_w;
	logic                          lvl_fire_w;
	logic                          div_start_w;
	logic                          div_done_w;
	logic [COUNT_WIDTH-1:0]        quo_w;
	logic [VW-1:0]                 rem_w;
	logic [COUNT_WIDTH-1:0]        rem_cnt_w;

	assign in_ready   = (state_q == ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign in_acc_w   = in_valid && in_ready;
	assign out_free_w = !out_valid_q || out_ready;

	// Elapsed ticks wrap at the tick width; the ms counter wraps at its own
	assign elapsed_w = in_data.now_tick - last_tick_q;
	assign ms_sum_w  = EXT_W'(ms_q) + EXT_W'(elapsed_w);

	// Select the counter under test and its divisor; zero acts as one
	always_comb begin
		case (level_q)
			cts_pkg::LVL_10MS:  operand_w = ms_q;
			cts_pkg::LVL_100MS: operand_w = tens_q;
			cts_pkg::LVL_1S:    operand_w = hund_q;
			cts_pkg::LVL_1MIN:  operand_w = sec_q;
			default:            operand_w = ms_q;
		endcase
	end

	assign div_raw_w   = div_q[level_q];
	assign divisor_w   = (div_raw_w == '0) ? VW'(1) : div_raw_w;
	assign lvl_fire_w  = CMP_W'(operand_w) >= CMP_W'(divisor_w);
	assign div_start_w = (state_q == ST_CHECK) && lvl_fire_w;
	assign rem_cnt_w   = COUNT_WIDTH'(rem_w);

	cts_div #(
		.DW (COUNT_WIDTH)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start_w),
		.dividend  (operand_w),
		.divisor   (divisor_w),
		.done      (div_done_w),
		.quotient  (quo_w),
		.remainder (rem_w)
	);

	// Sequencer, counters, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			level_q     <= cts_pkg::LVL_10MS;
			fire_q      <= '0;
			last_tick_q <= '0;
			elapsed_q   <= '0;
			ticks_q     <= '0;
			ms_q        <= '0;
			tens_q      <= '0;
			hund_q      <= '0;
			sec_q       <= '0;
			min_q       <= '0;
			div_q[cts_pkg::REG_DIV_MS_PER_10MS]    <= cts_pkg::DIV_MS_PER_10MS_RST;
			div_q[cts_pkg::REG_DIV_10MS_PER_100MS] <= cts_pkg::DIV_10MS_PER_100MS_RST;
			div_q[cts_pkg::REG_DIV_100MS_PER_SEC]  <= cts_pkg::DIV_100MS_PER_SEC_RST;
			div_q[cts_pkg::REG_DIV_SEC_PER_MIN]    <= cts_pkg::DIV_SEC_PER_MIN_RST;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// Write a divisor register
			if (cfg_valid) begin
				div_q[cfg_index] <= cfg_data;
			end

			// Drop the result once it is taken
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc_w) begin
						last_tick_q <= in_data.now_tick;
						if (in_data.command == cts_pkg::CMD_INIT) begin
							ms_q   <= '0;
							tens_q <= '0;
							hund_q <= '0;
							sec_q  <= '0;
							min_q  <= '0;
						end else if (elapsed_w != '0) begin
							ms_q      <= COUNT_WIDTH'(ms_sum_w);
							elapsed_q <= elapsed_w;
							fire_q    <= '0;
							ticks_q   <= '0;
							level_q   <= cts_pkg::LVL_10MS;
							state_q   <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					// Fire this level and divide, or stop the cascade here
					if (lvl_fire_w) begin
						fire_q[level_q] <= 1'b1;
						if (level_q == cts_pkg::LVL_10MS) begin
							ticks_q <= operand_w;
						end
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					if (div_done_w) begin
						// Keep the remainder, carry the quotient upward
						case (level_q)
							cts_pkg::LVL_10MS: begin
								ms_q   <= rem_cnt_w;
								tens_q <= tens_q + quo_w;
							end
							cts_pkg::LVL_100MS: begin
								tens_q <= rem_cnt_w;
								hund_q <= hund_q + quo_w;
							end
							cts_pkg::LVL_1S: begin
								hund_q <= rem_cnt_w;
								sec_q  <= sec_q + quo_w;
							end
							cts_pkg::LVL_1MIN: begin
								sec_q <= rem_cnt_w;
								min_q <= min_q + quo_w;
							end
							default: begin
								ms_q <= ms_q;
							end
						endcase
						if (level_q == cts_pkg::LVL_1MIN) begin
							state_q <= ST_DONE;
						end else begin
							level_q <= level_q + 2'd1;
							state_q <= ST_CHECK;
						end
					end
				end
				ST_DONE: begin
					// Load the result once the output register is free
					if (out_free_w) begin
						out_valid_q                <= 1'b1;
						out_data_q.elapsed_ticks   <= elapsed_q;
						out_data_q.fire_10ms       <= fire_q[cts_pkg::LVL_10MS];
						out_data_q.ticks_10ms      <= TW'(EXT_W'(ticks_q));
						out_data_q.fire_100ms      <= fire_q[cts_pkg::LVL_100MS];
						out_data_q.fire_1s         <= fire_q[cts_pkg::LVL_1S];
						out_data_q.fire_1min       <= fire_q[cts_pkg::LVL_1MIN];
						out_data_q.minutes_total   <= TW'(EXT_W'(min_q));
						state_q                    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

/* rtl/cts_checker.sv */
// Port-level assertions for the cascaded tick scheduler, bound to the top level.
`default_nettype none
module cts_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire cts_pkg::cts_out_t             out_data
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// A level fires only if the level below it fired
	a_fire_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_data.fire_100ms || out_data.fire_10ms) &&
			(!out_data.fire_1s || out_data.fire_100ms) &&
			(!out_data.fire_1min || out_data.fire_1s))
		else $error("fire flags out of cascade order");

	// Report ms ticks only when the 10 ms level fired
	a_ticks_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.fire_10ms |-> out_data.ticks_10ms == '0)
		else $error("ticks_10ms set without fire_10ms");

	// Never report a step with no elapsed ticks
	a_elapsed_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.elapsed_ticks != '0)
		else $error("result with zero elapsed ticks");

	// A fresh result comes with the sequencer back to idle
	a_ready_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result shown while still busy");

endmodule

bind cascaded_tick_scheduler cts_checker u_cts_checker (.*);
`default_nettype wire

/* tb/tb_cascaded_tick_scheduler.sv */
// Self-checking testbench for the cascaded tick scheduler: predicts the cascade and compares results.
`default_nettype none
module tb_cascaded_tick_scheduler;
	timeunit 1ns;
	timeprecision 1ps;

	import cts_pkg::*;

	localparam int COUNT_W        = COUNT_WIDTH_DEF;
	localparam int SETTLE_CYCLES  = 100;
	localparam int QUIET_LIMIT    = 5000;
	localparam int REPORT_LIMIT   = 10;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	cts_in_t              in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	cts_out_t             out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_DIV_MS_PER_10MS;
	logic [DIV_W-1:0]     cfg_data  = '0;

	// Predicted timebase state and divisor registers
	logic [TICK_W-1:0]  last_tick_q = '0;
	logic [COUNT_W-1:0] ms_q        = '0;
	logic [COUNT_W-1:0] tens_q      = '0;
	logic [COUNT_W-1:0] hundreds_q  = '0;
	logic [COUNT_W-1:0] sec_q       = '0;
	logic [COUNT_W-1:0] min_q       = '0;
	logic [DIV_W-1:0]   divisors [LEVELS];

	cts_out_t    due_reports [$];
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles   = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;

	cascaded_tick_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Generate the 100 MHz clock
	always begin
		clk = 1'b0;
		#5ns;
		clk = 1'b1;
		#5ns;
	end

	// Drive the result side ready, stalling at the current rate
	always @(posedge clk) begin
		out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
	end

	// Count cycles in which no channel moves an item
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	function automatic void flag_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("mismatch on %s: expected %0d, got %0d", what, want, got);
	endfunction

	// Zero in a divisor register counts as one
	function automatic logic [COUNT_W-1:0] eff_div(input logic [CFG_IDX_W-1:0] idx);
		return (divisors[idx] == '0) ? COUNT_W'(1) : COUNT_W'(divisors[idx]);
	endfunction

	// Advance the predicted timebase by one item; return 1 when a result is due
	function automatic bit advance_timebase(input cts_in_t item, output cts_out_t res);
		logic [TICK_W-1:0]  elapsed;
		logic [COUNT_W-1:0] d;
		res = '0;
		if (item.command == CMD_INIT) begin
			ms_q        = '0;
			tens_q      = '0;
			hundreds_q  = '0;
			sec_q       = '0;
			min_q       = '0;
			last_tick_q = item.now_tick;
			return 1'b0;
		end
		elapsed     = item.now_tick - last_tick_q;
		last_tick_q = item.now_tick;
		if (elapsed == '0)
			return 1'b0;
		ms_q = ms_q + COUNT_W'(elapsed);
		res.elapsed_ticks = elapsed;
		// Carry through each level only while the one below fires
		d = eff_div(REG_DIV_MS_PER_10MS);
		if (ms_q >= d) begin
			res.fire_10ms  = 1'b1;
			res.ticks_10ms = TICK_W'(ms_q);
			tens_q = tens_q + ms_q / d;
			ms_q   = ms_q % d;
			d = eff_div(REG_DIV_10MS_PER_100MS);
			if (tens_q >= d) begin
				res.fire_100ms = 1'b1;
				hundreds_q = hundreds_q + tens_q / d;
				tens_q     = tens_q % d;
				d = eff_div(REG_DIV_100MS_PER_SEC);
				if (hundreds_q >= d) begin
					res.fire_1s = 1'b1;
					sec_q      = sec_q + hundreds_q / d;
					hundreds_q = hundreds_q % d;
					d = eff_div(REG_DIV_SEC_PER_MIN);
					if (sec_q >= d) begin
						res.fire_1min = 1'b1;
						min_q = min_q + sec_q / d;
						sec_q = sec_q % d;
					end
				end
			end
		end
		res.minutes_total = TICK_W'(min_q);
		return 1'b1;
	endfunction

	// Compare each delivered result with the oldest one due
	always @(posedge clk) begin : check_results
		cts_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_reports.size() == 0) begin
				flag_mismatch("result with nothing due, elapsed_ticks", 32'd0,
					32'(out_data.elapsed_ticks));
			end else begin
				want = due_reports.pop_front();
				if (out_data.elapsed_ticks !== want.elapsed_ticks)
					flag_mismatch("elapsed_ticks", 32'(want.elapsed_ticks),
						32'(out_data.elapsed_ticks));
				if (out_data.fire_10ms !== want.fire_10ms)
					flag_mismatch("fire_10ms", 32'(want.fire_10ms),
						32'(out_data.fire_10ms));
				if (out_data.ticks_10ms !== want.ticks_10ms)
					flag_mismatch("ticks_10ms", 32'(want.ticks_10ms),
						32'(out_data.ticks_10ms));
				if (out_data.fire_100ms !== want.fire_100ms)
					flag_mismatch("fire_100ms", 32'(want.fire_100ms),
						32'(out_data.fire_100ms));
				if (out_data.fire_1s !== want.fire_1s)
					flag_mismatch("fire_1s", 32'(want.fire_1s),
						32'(out_data.fire_1s));
				if (out_data.fire_1min !== want.fire_1min)
					flag_mismatch("fire_1min", 32'(want.fire_1min),
						32'(out_data.fire_1min));
				if (out_data.minutes_total !== want.minutes_total)
					flag_mismatch("minutes_total", 32'(want.minutes_total),
						32'(out_data.minutes_total));
			end
		end
	end

	function automatic cts_in_t tick_item(input logic cmd, input logic [TICK_W-1:0] tick);
		cts_in_t item;
		item.command  = cmd;
		item.now_tick = tick;
		return item;
	endfunction

	function automatic logic [DIV_W-1:0] rand_div(input int unsigned lo, input int unsigned hi);
		return DIV_W'($urandom_range(hi, lo));
	endfunction

	// Mostly runs a plausible distance ahead; some zero steps, jumps and inits
	function automatic cts_in_t random_tick_item();
		int unsigned       pick;
		logic [TICK_W-1:0] delta;
		pick = $urandom_range(99);
		if (pick < 4)
			return tick_item(CMD_INIT, TICK_W'($urandom));
		if (pick < 12)
			return tick_item(CMD_RUN, last_tick_q);
		if (pick < 20)
			return tick_item(CMD_RUN, TICK_W'($urandom));
		if (pick < 60)
			delta = TICK_W'($urandom_range(30, 1));
		else if (pick < 88)
			delta = TICK_W'($urandom_range(3000, 31));
		else
			delta = TICK_W'($urandom_range(65535, 3001));
		return tick_item(CMD_RUN, last_tick_q + delta);
	endfunction

	// Offer one item, hold it until taken, then predict its result
	task automatic send_item(input cts_in_t item);
		cts_out_t res;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		if (advance_timebase(item, res))
			due_reports.push_back(res);
	endtask

	task automatic send_run_after(input logic [TICK_W-1:0] delta);
		send_item(tick_item(CMD_RUN, last_tick_q + delta));
	endtask

	// Drop valid, wait for every due result, then let the sequencer finish
	task automatic drain_block();
		in_valid <= 1'b0;
		while (due_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_divisors(input logic [DIV_W-1:0] d10ms, input logic [DIV_W-1:0] d100ms,
			input logic [DIV_W-1:0] d1s, input logic [DIV_W-1:0] d1min);
		logic [DIV_W-1:0]     vals [LEVELS];
		logic [CFG_IDX_W-1:0] regs [LEVELS];
		vals = '{d10ms, d100ms, d1s, d1min};
		regs = '{REG_DIV_MS_PER_10MS, REG_DIV_10MS_PER_100MS, REG_DIV_100MS_PER_SEC,
			REG_DIV_SEC_PER_MIN};
		drain_block();
		for (int i = 0; i < LEVELS; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			divisors[regs[i]] = vals[i];
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_traffic(input int unsigned count, input int unsigned idle_pct,
			input int unsigned stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) send_item(random_tick_item());
	endtask

	// Reset divisors: zero steps, tick wrap, exact divisor hit, full cascade, init
	task automatic test_default_cascade();
		send_item(tick_item(CMD_RUN, 16'h0000));
		send_item(tick_item(CMD_RUN, 16'h0001));
		send_item(tick_item(CMD_RUN, 16'h000A));
		send_item(tick_item(CMD_RUN, 16'hFFFF));
		send_item(tick_item(CMD_RUN, 16'h0000));
		send_item(tick_item(CMD_INIT, 16'hFFFF));
		send_item(tick_item(CMD_RUN, 16'hFFFF));
		send_item(tick_item(CMD_RUN, 16'hFFFE));
		send_item(tick_item(CMD_RUN, 16'hEA5E));
		send_item(tick_item(CMD_INIT, 16'h5555));
		send_item(tick_item(CMD_RUN, 16'hAAAA));
		send_item(tick_item(CMD_INIT, 16'h0000));
		send_item(tick_item(CMD_RUN, 16'h0009));
		send_item(tick_item(CMD_RUN, 16'h000A));
	endtask

	// Divisor extremes: unit and zero divisors, widest divisors, counter wrap
	task automatic test_divisor_extremes();
		program_divisors(10'd1, 10'd1, 10'd1, 10'd1);
		send_run_after(16'hFFFF);
		send_run_after(16'hFFFF);
		program_divisors('0, '0, '0, '0);
		send_run_after(16'h0002);
		send_run_after(16'hFFFF);
		program_divisors(10'd1000, 10'd1000, 10'd1000, 10'd1000);
		send_run_after(16'd999);
		send_run_after(16'd65000);
		program_divisors(10'd1, 10'd1023, 10'd1, 10'd1);
		send_run_after(16'd1022);
		send_run_after(16'hFFFF);
		send_item(tick_item(CMD_INIT, last_tick_q));
		send_run_after(16'hFFFF);
	endtask

	// Random traffic across divisor settings and handshake pressure
	task automatic test_random_phases();
		program_divisors(DIV_MS_PER_10MS_RST, DIV_10MS_PER_100MS_RST, DIV_100MS_PER_SEC_RST,
			DIV_SEC_PER_MIN_RST);
		run_traffic(200, 0, 0);
		program_divisors(rand_div(1, 1000), rand_div(1, 1000), rand_div(1, 1000),
			rand_div(1, 1000));
		run_traffic(200, 70, 0);
		program_divisors(rand_div(1, 6), rand_div(1, 6), rand_div(1, 6), rand_div(1, 6));
		run_traffic(250, 0, 70);
		program_divisors(rand_div(0, 1023), rand_div(0, 1023), rand_div(0, 1023),
			rand_div(0, 1023));
		run_traffic(250, 29, 29);
		program_divisors(10'd1000, 10'd1000, 10'd1023, 10'd1023);
		run_traffic(150, 0, 0);
		program_divisors(rand_div(1, 3), rand_div(1, 3), rand_div(1, 3), rand_div(1, 3));
		run_traffic(250, 29, 29);
		program_divisors(rand_div(0, 1023), rand_div(1, 4), rand_div(0, 1023), rand_div(1, 4));
		run_traffic(150, 70, 0);
		program_divisors(DIV_MS_PER_10MS_RST, DIV_10MS_PER_100MS_RST, DIV_100MS_PER_SEC_RST,
			DIV_SEC_PER_MIN_RST);
		run_traffic(200, 0, 70);
	endtask

	// End the run when the channels go quiet for too long
	initial begin : watchdog
		wait (arst_n === 1'b1);
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		divisors[REG_DIV_MS_PER_10MS]    = DIV_MS_PER_10MS_RST;
		divisors[REG_DIV_10MS_PER_100MS] = DIV_10MS_PER_100MS_RST;
		divisors[REG_DIV_100MS_PER_SEC]  = DIV_100MS_PER_SEC_RST;
		divisors[REG_DIV_SEC_PER_MIN]    = DIV_SEC_PER_MIN_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_cascade();
		test_divisor_extremes();
		test_random_phases();

		drain_block();
		if (due_reports.size() != 0)
			flag_mismatch("results still due at end", 32'd0, unsigned'(due_reports.size()));
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
`default_nettype wire
